/* rtl/airtime_admission_control_assert.svh */
// assertion helpers for the rtl files, included by airtime_admission_control
`ifndef AIRTIME_ADMISSION_CONTROL_ASSERT_SVH
`define AIRTIME_ADMISSION_CONTROL_ASSERT_SVH

// same-cycle implication on i_clk, off during reset
`define AAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication on i_clk, off during reset
`define AAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/aac_pkg.sv */
//------------------------------------------------------------------------------
// aac_pkg
// shared types and codes of the airtime admission control block
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package aac_pkg;

    localparam int unsigned DIV_W = 32;   // quotient bits per division
    localparam int unsigned REM_W = 35;   // remainder and divisor bits

    typedef logic [2:0] t_status;

    localparam t_status ST_ADMIT    = 3'd0;
    localparam t_status ST_OVER     = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_BAD_SIZE = 3'd3;
    localparam t_status ST_RELEASED = 3'd4;
    localparam t_status ST_UNKNOWN  = 3'd5;

    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] num;
        logic [REM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

/* rtl/aac_div.sv */
//------------------------------------------------------------------------------
// aac_div
// bit-serial restoring divider, one quotient bit per cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module aac_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aac_pkg::t_div_req i_req,
    output aac_pkg::t_div_rsp o_rsp
);
    import aac_pkg::*;

    localparam int unsigned CW = $clog2(DIV_W);

    logic [REM_W-1:0] r_rem;
    logic [DIV_W-1:0] r_num;
    logic [REM_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [REM_W:0]   w_sh;
    logic [REM_W:0]   w_diff;

    // remainder stays below the divisor, so the shifted value fits
    assign w_sh   = {r_rem, r_num[DIV_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (!w_diff[REM_W]) begin
                r_rem <= w_diff[REM_W-1:0];
                r_num <= {r_num[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[REM_W-1:0];
                r_num <= {r_num[DIV_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

/* rtl/airtime_admission_control.sv */
//------------------------------------------------------------------------------
// airtime_admission_control
// admits or releases flows against an airtime budget on a he channel
//------------------------------------------------------------------------------
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready    tuser kind, tdata request
// m_axis    out  m_axis_tvalid / m_axis_tready    tuser status, tdata result
// cfg       in   i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// a request runs a symbol division, a shift-add multiply and an airtime
// division, skipped on overflow (both divisions share one serial divider),
// plus control; a request with zero size goes straight to a bad-size result;
// a release scans the flow table slot by slot (memory read then compare)
// the free slot scan runs beside the arithmetic, one slot per cycle
// reset is synchronous, active low; the flow table needs no clearing pass
// one item is in work at a time; a finished item waits in the output register
// while the next one is accepted
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module airtime_admission_control #(
    parameter int unsigned MAX_FLOWS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [24:0]          i_cfg_data,
    // request items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // packet_size[15:0], data_rate[47:16], traffic_type[50:48],
    // release_id[82:51], zero fill
    input  logic [87:0]          s_axis_tdata,
    // kind[0]
    input  logic [0:0]           s_axis_tuser,
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // flow_id[31:0], required_airtime[63:32], access_category[65:64],
    // priority_res[68:66], utilization[93:69], blocked_count[125:94],
    // request_count[157:126], zero fill
    output logic [159:0]         m_axis_tdata,
    // status[2:0]
    output aac_pkg::t_status     m_axis_tuser
);
    import aac_pkg::*;

    `include "airtime_admission_control_assert.svh"

    localparam int unsigned IW    = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int unsigned T11_W = 22;                 // 11 * packet time
    localparam int unsigned MCW   = $clog2(T11_W);
    localparam int unsigned ACC_W = 54;                 // rate * 11 * time

    // register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_STREAMS   = 2'd2;

    localparam logic KIND_RELEASE = 1'b1;

    // traffic types
    localparam logic [2:0] TT_VOICE = 3'd0;
    localparam logic [2:0] TT_VIDEO = 3'd1;
    localparam logic [2:0] TT_WEB   = 3'd3;

    // data bits per he symbol and stream, by channel width
    localparam logic [10:0] SYM_CAP [4] = '{11'd234, 11'd468, 11'd980, 11'd1960};

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL_RD,
        S_REL_CMP,
        S_BAD,
        S_SYM,
        S_SYM_WAIT,
        S_MUL,
        S_CHK,
        S_DIV2,
        S_DEC
    } t_state;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    t_state           r_state;

    // config
    logic [24:0]      r_thr;
    logic [1:0]       r_wc;
    logic [3:0]       r_ns;

    // captured item
    logic [15:0]      r_size;
    logic [31:0]      r_rate;
    logic [2:0]       r_type;
    logic [31:0]      r_rid;

    // block state
    logic [24:0]      r_total;
    logic [31:0]      r_next_id;
    logic [31:0]      r_seen;
    logic [31:0]      r_blocked;
    logic [MAX_FLOWS-1:0] r_valid;

    // flow table: id and airtime per slot
    logic [56:0]      r_mem [MAX_FLOWS];
    logic [56:0]      r_rd;
    logic [IW-1:0]    r_addr;

    // free slot scan
    logic [IW-1:0]    r_scan;
    logic             r_scan_done;
    logic             r_free_ok;

    // arithmetic
    logic [34:0]      r_den;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_mcand;
    logic [T11_W-1:0] r_mplier;
    logic [MCW-1:0]   r_mcnt;
    logic [31:0]      r_air;

    // output register
    logic             r_m_valid;
    t_status          r_m_status;
    logic [31:0]      r_m_fid;
    logic [31:0]      r_m_air;
    logic [1:0]       r_m_ac;
    logic [2:0]       r_m_pri;

    logic [16:0]      w_bytes;
    logic [3:0]       w_nss;
    logic [14:0]      w_cap;
    logic [20:0]      w_sym_num;
    logic [18:0]      w_t;
    logic [T11_W-1:0] w_t11;
    logic             w_ovf;
    logic [32:0]      w_sum;
    logic             w_out_free;
    logic             w_rel_hit;
    logic             w_rel_last;
    logic             w_commit;
    logic [1:0]       w_ac;
    logic [2:0]       w_pri;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);

    // bytes on air per packet, with mac overhead
    assign w_bytes   = 17'(r_size) + ((r_type <= TT_VIDEO) ? 17'd44 : 17'd42);
    assign w_nss     = (r_ns == 4'd0) ? 4'd1 : r_ns;
    assign w_cap     = 15'(SYM_CAP[r_wc] * w_nss);
    // ceiling of bits over capacity
    assign w_sym_num = {1'b0, w_bytes, 3'b000} + 21'(w_cap) - 21'd1;
    // packet time in 0.1us: 201.5us fixed plus 13.6us per symbol
    assign w_t       = 19'd2015 + 19'({7'd0, w_div_rsp.quot[11:0]} * 19'd136);
    assign w_t11     = T11_W'({3'd0, w_t} * T11_W'(11));

    // quotient would need more than 32 bits after the 13-bit shift
    assign w_ovf     = (r_acc >= {r_den, 19'd0});
    assign w_sum     = {8'd0, r_total} + {1'b0, r_air};

    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_rel_hit  = r_valid[r_addr] && (r_rd[56:25] == r_rid);
    assign w_rel_last = (r_addr == IW'(MAX_FLOWS - 1));
    assign w_commit   = w_out_free && (
                          (r_state == S_BAD) ||
                          (r_state == S_DEC && r_scan_done) ||
                          (r_state == S_REL_CMP && (w_rel_hit || w_rel_last)));

    assign w_ac  = (r_type == TT_VOICE) ? 2'd2 : (r_type == TT_VIDEO) ? 2'd1 : 2'd0;
    assign w_pri = (r_type <= TT_WEB) ? 3'd4 - r_type : 3'd0;

    // shared divider: symbol count first, then the airtime quotient
    always_comb begin
        w_div_req.start = 1'b0;
        w_div_req.rem   = '0;
        w_div_req.num   = {11'd0, w_sym_num};
        w_div_req.den   = {20'd0, w_cap};
        case (r_state)
            S_SYM: begin
                w_div_req.start = 1'b1;
            end
            S_CHK: begin
                w_div_req.start = !w_ovf;
                w_div_req.rem   = r_acc[ACC_W-1:19];
                w_div_req.num   = {r_acc[18:0], 13'd0};
                w_div_req.den   = r_den;
            end
            default: begin
                w_div_req.start = 1'b0;
            end
        endcase
    end

    aac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // flow table memory
    always_ff @(posedge i_clk) begin
        if (w_commit && r_state == S_DEC && !(w_sum > {8'd0, r_thr}) && r_free_ok) begin
            r_mem[r_scan] <= {r_next_id, r_air[24:0]};
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= 25'd13421773;
            r_wc        <= 2'd2;
            r_ns        <= 4'd2;
            r_total     <= '0;
            r_next_id   <= 32'd1;
            r_seen      <= '0;
            r_blocked   <= '0;
            r_valid     <= '0;
            r_m_valid   <= 1'b0;
            r_scan_done <= 1'b0;
        end else begin
            // config writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_thr <= i_cfg_data;
                    CFG_WIDTH:     r_wc  <= i_cfg_data[1:0];
                    CFG_STREAMS:   r_ns  <= i_cfg_data[3:0];
                    default:       ;
                endcase
            end

            // a new result takes over the register in the same cycle
            if (m_axis_tready && !w_commit) begin
                r_m_valid <= 1'b0;
            end

            // lowest free slot, one slot per cycle
            if (r_state != S_IDLE && !r_scan_done) begin
                if (!r_valid[r_scan]) begin
                    r_scan_done <= 1'b1;
                    r_free_ok   <= 1'b1;
                end else if (r_scan == IW'(MAX_FLOWS - 1)) begin
                    r_scan_done <= 1'b1;
                    r_free_ok   <= 1'b0;
                end else begin
                    r_scan <= r_scan + 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_size      <= s_axis_tdata[15:0];
                        r_rate      <= s_axis_tdata[47:16];
                        r_type      <= s_axis_tdata[50:48];
                        r_rid       <= s_axis_tdata[82:51];
                        r_scan      <= '0;
                        r_scan_done <= 1'b0;
                        r_addr      <= '0;
                        if (s_axis_tuser[0] == KIND_RELEASE) begin
                            r_state <= S_REL_RD;
                        end else if (s_axis_tdata[15:0] == 16'd0) begin
                            r_state <= S_BAD;
                        end else begin
                            r_state <= S_SYM;
                        end
                    end
                end
                S_REL_RD: begin
                    r_state <= S_REL_CMP;
                end
                S_REL_CMP: begin
                    if (w_commit) begin
                        r_m_valid <= 1'b1;
                        r_m_fid   <= '0;
                        r_m_air   <= '0;
                        r_m_ac    <= '0;
                        r_m_pri   <= '0;
                        if (w_rel_hit) begin
                            r_m_status       <= ST_RELEASED;
                            r_valid[r_addr]  <= 1'b0;
                            r_total <= (r_total >= r_rd[24:0]) ? r_total - r_rd[24:0] : '0;
                        end else begin
                            r_m_status <= ST_UNKNOWN;
                        end
                        r_state <= S_IDLE;
                    end else if (!w_rel_hit && !w_rel_last) begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_REL_RD;
                    end
                end
                S_BAD: begin
                    if (w_commit) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= ST_BAD_SIZE;
                        r_m_fid    <= '0;
                        r_m_air    <= '0;
                        r_m_ac     <= w_ac;
                        r_m_pri    <= w_pri;
                        r_seen     <= sat_inc(r_seen);
                        r_blocked  <= sat_inc(r_blocked);
                        r_state    <= S_IDLE;
                    end
                end
                S_SYM: begin
                    r_den   <= 35'(r_size) * 35'd390625;
                    r_state <= S_SYM_WAIT;
                end
                S_SYM_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_acc    <= '0;
                        r_mcand  <= ACC_W'(r_rate);
                        r_mplier <= w_t11;
                        r_mcnt   <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    // one multiplier bit per cycle
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[ACC_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[T11_W-1:1]};
                    r_mcnt   <= r_mcnt + 1'b1;
                    if (r_mcnt == MCW'(T11_W - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (w_ovf) begin
                        r_air   <= '1;
                        r_state <= S_DEC;
                    end else begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_div_rsp.done) begin
                        r_air   <= w_div_rsp.quot;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (w_commit) begin
                        r_m_valid <= 1'b1;
                        r_m_air   <= r_air;
                        r_m_ac    <= w_ac;
                        r_m_pri   <= w_pri;
                        r_seen    <= sat_inc(r_seen);
                        if (w_sum > {8'd0, r_thr}) begin
                            r_m_status <= ST_OVER;
                            r_m_fid    <= '0;
                            r_blocked  <= sat_inc(r_blocked);
                        end else if (!r_free_ok) begin
                            r_m_status <= ST_FULL;
                            r_m_fid    <= '0;
                            r_blocked  <= sat_inc(r_blocked);
                        end else begin
                            r_m_status      <= ST_ADMIT;
                            r_m_fid         <= r_next_id;
                            r_next_id       <= r_next_id + 32'd1;
                            r_valid[r_scan] <= 1'b1;
                            r_total         <= w_sum[24:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // counters and utilization hold until the result is taken
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {2'd0, r_seen, r_blocked, r_total, r_m_pri, r_m_ac,
                            r_m_air, r_m_fid};

    // committed airtime moves only when a result is produced
    `AAC_ASSERT_NXT(a_total_on_commit, !w_commit, $stable(r_total))
    // at most one slot is taken per item
    `AAC_ASSERT_NXT(a_valid_step, 1'b1, $countones(r_valid) <= $past($countones(r_valid)) + 1)
    // divider is never restarted while a division runs
    `AAC_ASSERT_IMP(a_div_free, w_div_req.start, !w_div_rsp.busy)

endmodule
